@@ design/crt_scanline_vignette_pixel_top_macros.svh @@
`ifndef CRT_SCANLINE_VIGNETTE_PIXEL_TOP_MACROS_SVH
`define CRT_SCANLINE_VIGNETTE_PIXEL_TOP_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define CRTSV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define CRTSV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/crtsv_pkg.sv @@
package crtsv_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int CHAN_W     = 8;
    localparam int SPACING_W  = 12;
    localparam int DARK_W     = 8;
    localparam int STR_W      = 9;
    localparam int SIZE_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // normalized center distance is kept to 9 bits; 330 and up already
    // drives the tube factor to its floor
    localparam int NORM_W = 9;
    localparam int CORNER_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPACING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_DARKNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [SPACING_W-1:0] RST_LINE_SPACING  = 12'd2;
    localparam logic [DARK_W-1:0]    RST_LINE_DARKNESS = 8'd64;
    localparam logic [STR_W-1:0]     RST_STRENGTH      = 9'd256;
    localparam logic [SIZE_W-1:0]    RST_IMAGE_WIDTH   = 13'd320;
    localparam logic [SIZE_W-1:0]    RST_IMAGE_HEIGHT  = 13'd240;

    localparam logic [CHAN_W-1:0]   FULL              = 8'd255;
    localparam logic [STR_W-1:0]    STR_FULL          = 9'd256;
    localparam logic [CHAN_W-1:0]   TUBE_MIN          = 8'd40;
    localparam logic [CORNER_W-1:0] TUBE_KNEE         = 11'd210;
    localparam logic [CORNER_W-1:0] TUBE_FLOOR_CORNER = 11'd425;
    localparam logic [CORNER_W-1:0] TUBE_BASE         = 11'd465;
    localparam logic [NORM_W-1:0]   NORM_SAT          = 9'h1FF;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [2*CHAN_W-1:0] red;
        logic [2*CHAN_W-1:0] green;
        logic [2*CHAN_W-1:0] blue;
    } wrgb_t;

    typedef struct packed {
        rgb_t              color;
        logic [CHAN_W-1:0] coverage;
        logic              masked;
    } pix_t;

endpackage

@@ design/crt_scanline_vignette_pixel_top.sv @@
// channel   | handshake              | word
// ----------+------------------------+------------------------------------------------
// cfg       | cfg_we                 | cfg_index, cfg_data
// in        | in_valid / in_ready    | x_pos, y_pos, red_in, green_in, blue_in,
//           |                        | coverage, masked
// out       | out_valid / out_ready  | red_out, green_out, blue_out
//
// One pixel per cycle while no skid word is held. The restoring divide for the center
// distance and the row modulo take one bit per stage.
// Reset clears config to defaults and all valid bits; no clearing pass.
// Output register plus one skid word: in_ready drops only once both hold a word,
// and the whole pipe then holds until out_ready frees the skid.
`include "crt_scanline_vignette_pixel_top_macros.svh"

module crt_scanline_vignette_pixel_top
    import crtsv_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_pos,
    input  logic [COORD_BITS-1:0] y_pos,
    input  logic [CHAN_W-1:0]     red_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     blue_in,
    input  logic [CHAN_W-1:0]     coverage,
    input  logic                  masked,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CHAN_W-1:0]     red_out,
    output logic [CHAN_W-1:0]     green_out,
    output logic [CHAN_W-1:0]     blue_out
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = (CB + 1 > SIZE_W) ? CB + 1 : SIZE_W;
    localparam int NW  = DW + CHAN_W;
    localparam int MW  = CB + SPACING_W;
    localparam int K   = (CB > NORM_W) ? CB : NORM_W;
    localparam int NST = K + 10;

    typedef struct packed {
        logic [NW-1:0]     remx;
        logic [NW-1:0]     remy;
        logic [NORM_W-1:0] qx;
        logic [NORM_W-1:0] qy;
        logic              ovx;
        logic              ovy;
        logic              zx;
        logic              zy;
        logic [CB-1:0]     remm;
        pix_t              pix;
    } it_t;

    // one restoring step: a quotient bit of each distance divide and a
    // remainder bit of the row modulo
    function automatic it_t it_step(input it_t s, input int k,
                                    input logic [SIZE_W-1:0] w,
                                    input logic [SIZE_W-1:0] h,
                                    input logic [SPACING_W-1:0] sp);
        it_t          r;
        logic [NW:0]  xs;
        logic [NW:0]  ys;
        logic [MW:0]  ms;
        r  = s;
        xs = '0;
        ys = '0;
        ms = '0;
        if (k < NORM_W)
        begin
            xs = {1'b0, s.remx} - ((NW+1)'(w) << (NORM_W - 1 - k));
            ys = {1'b0, s.remy} - ((NW+1)'(h) << (NORM_W - 1 - k));
            if (!xs[NW])
            begin
                r.remx = xs[NW-1:0];
            end
            if (!ys[NW])
            begin
                r.remy = ys[NW-1:0];
            end
            r.qx = {s.qx[NORM_W-2:0], ~xs[NW]};
            r.qy = {s.qy[NORM_W-2:0], ~ys[NW]};
        end
        if (k < CB)
        begin
            ms = {1'b0, MW'(s.remm)} - ((MW+1)'(sp) << (CB - 1 - k));
            if (!ms[MW])
            begin
                r.remm = ms[CB-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] scale_ch(input logic [CHAN_W-1:0] c,
                                                   input logic [CHAN_W-1:0] g);
        logic [2*CHAN_W-1:0] p;
        p = (2*CHAN_W)'(c) * (2*CHAN_W)'(g);
        return p[2*CHAN_W-1:CHAN_W];
    endfunction

    function automatic logic [2*CHAN_W-1:0] ease_wt(input logic [CHAN_W-1:0] c,
                                                    input logic [CHAN_W-1:0] n,
                                                    input logic [CHAN_W-1:0] cov);
        logic [CHAN_W-1:0] d;
        d = c - n;
        return (2*CHAN_W)'(d) * (2*CHAN_W)'(cov);
    endfunction

    // c + floor((n - c) * cov / 256) with n <= c
    function automatic logic [CHAN_W-1:0] ease_out(input logic [CHAN_W-1:0] c,
                                                   input logic [2*CHAN_W-1:0] a);
        logic [2*CHAN_W:0] t;
        t = (2*CHAN_W+1)'(a) + (2*CHAN_W+1)'(FULL);
        return c - t[2*CHAN_W-1:CHAN_W];
    endfunction

    // configuration
    logic [SPACING_W-1:0] line_spacing_reg;
    logic [DARK_W-1:0]    line_darkness_reg;
    logic [STR_W-1:0]     strength_reg;
    logic [SIZE_W-1:0]    image_width_reg;
    logic [SIZE_W-1:0]    image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_spacing_reg  <= RST_LINE_SPACING;
            line_darkness_reg <= RST_LINE_DARKNESS;
            strength_reg      <= RST_STRENGTH;
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_SPACING:  line_spacing_reg  <= cfg_data[SPACING_W-1:0];
                CFG_LINE_DARKNESS: line_darkness_reg <= cfg_data[DARK_W-1:0];
                CFG_STRENGTH:      strength_reg      <= cfg_data[STR_W-1:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    logic [SPACING_W-1:0] sp_eff;
    logic [STR_W-1:0]     str_eff;

    assign sp_eff  = (line_spacing_reg == '0) ? SPACING_W'(1) : line_spacing_reg;
    assign str_eff = (strength_reg > STR_FULL) ? STR_FULL : strength_reg;

    // flow control
    logic            en;
    logic            push;
    logic [NST-1:0]  vld_reg;
    logic            out_vld_reg;
    logic            skid_vld_reg;
    rgb_t            out_data_reg;
    rgb_t            skid_data_reg;
    rgb_t            res_next;

    assign en       = !skid_vld_reg;
    assign in_ready = en;
    assign push     = en && vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // pipeline payload
    logic [CB-1:0]  x0_reg;
    logic [CB-1:0]  y0_reg;
    pix_t           pix0_reg;

    logic [DW-1:0]  dx1_next;
    logic [DW-1:0]  dy1_next;
    logic [DW-1:0]  dx1_reg;
    logic [DW-1:0]  dy1_reg;
    logic [CB-1:0]  y1_reg;
    pix_t           pix1_reg;

    it_t            pp_next;
    it_t            pp_reg;
    it_t            it_next [K];
    it_t            it_reg  [K];

    logic [NORM_W-1:0]   nx;
    logic [NORM_W-1:0]   ny;
    logic [2*NORM_W-1:0] sqx_next;
    logic [2*NORM_W-1:0] sqy_next;
    logic [2*NORM_W-1:0] sqx_reg;
    logic [2*NORM_W-1:0] sqy_reg;
    logic                hit_reg;
    pix_t                pix_q1_reg;

    logic [2*NORM_W:0]   dist_sum;
    logic [CORNER_W-1:0] corner;
    logic [CHAN_W-1:0]   tube_next;
    logic [CHAN_W-1:0]   line_next;
    logic [CHAN_W-1:0]   tube_reg;
    logic [CHAN_W-1:0]   line_reg;
    pix_t                pix_q2_reg;

    logic [2*CHAN_W-1:0] prod_reg;
    pix_t                pix_q3_reg;

    logic [2*CHAN_W:0]   p1;
    logic [2*CHAN_W:0]   p2;
    logic [CHAN_W-1:0]   f_reg;
    pix_t                pix_q4_reg;

    logic [2*CHAN_W:0]   dk;
    logic [CHAN_W-1:0]   g_next;
    logic [CHAN_W-1:0]   g_reg;
    pix_t                pix_q5_reg;

    rgb_t                n6_next;
    rgb_t                n6_reg;
    pix_t                pix_q6_reg;

    wrgb_t               a7_next;
    wrgb_t               a7_reg;
    rgb_t                n7_reg;
    pix_t                pix_q7_reg;

    always_comb
    begin
        logic [DW-1:0] twx;
        logic [DW-1:0] twy;
        logic [DW-1:0] wd;
        logic [DW-1:0] hd;
        twx = DW'({x0_reg, 1'b0});
        twy = DW'({y0_reg, 1'b0});
        wd  = DW'(image_width_reg);
        hd  = DW'(image_height_reg);
        dx1_next = (twx >= wd) ? twx - wd : wd - twx;
        dy1_next = (twy >= hd) ? twy - hd : hd - twy;
    end

    // distance * 255, and a quotient of 512 or more is flagged up front
    always_comb
    begin
        pp_next.remx = {dx1_reg, {CHAN_W{1'b0}}} - NW'(dx1_reg);
        pp_next.remy = {dy1_reg, {CHAN_W{1'b0}}} - NW'(dy1_reg);
        pp_next.qx   = '0;
        pp_next.qy   = '0;
        pp_next.zx   = (image_width_reg == '0);
        pp_next.zy   = (image_height_reg == '0);
        pp_next.ovx  = {1'b0, pp_next.remx} >= ((NW+1)'(image_width_reg) << NORM_W);
        pp_next.ovy  = {1'b0, pp_next.remy} >= ((NW+1)'(image_height_reg) << NORM_W);
        pp_next.remm = y1_reg;
        pp_next.pix  = pix1_reg;
    end

    always_comb
    begin
        it_next[0] = it_step(pp_reg, 0, image_width_reg, image_height_reg, sp_eff);
        for (int k = 1; k < K; k++)
        begin
            it_next[k] = it_step(it_reg[k-1], k, image_width_reg, image_height_reg, sp_eff);
        end
    end

    always_comb
    begin
        if (it_reg[K-1].zx)
        begin
            nx = '0;
        end
        else
        begin
            nx = it_reg[K-1].ovx ? NORM_SAT : it_reg[K-1].qx;
        end
        if (it_reg[K-1].zy)
        begin
            ny = '0;
        end
        else
        begin
            ny = it_reg[K-1].ovy ? NORM_SAT : it_reg[K-1].qy;
        end
        sqx_next = (2*NORM_W)'(nx) * (2*NORM_W)'(nx);
        sqy_next = (2*NORM_W)'(ny) * (2*NORM_W)'(ny);
    end

    always_comb
    begin
        dist_sum = (2*NORM_W+1)'(sqx_reg) + (2*NORM_W+1)'(sqy_reg);
        corner   = dist_sum[2*NORM_W:8];
        priority if (corner <= TUBE_KNEE)
        begin
            tube_next = FULL;
        end
        else if (corner >= TUBE_FLOOR_CORNER)
        begin
            tube_next = TUBE_MIN;
        end
        else
        begin
            tube_next = CHAN_W'(TUBE_BASE - corner);
        end
        line_next = hit_reg ? FULL - line_darkness_reg : FULL;
    end

    // floor(p / 255) for p up to 255 * 255
    assign p1 = (2*CHAN_W+1)'(prod_reg) + (2*CHAN_W+1)'(1);
    assign p2 = p1 + (p1 >> CHAN_W);

    always_comb
    begin
        dk     = (2*CHAN_W+1)'(FULL - f_reg) * (2*CHAN_W+1)'(str_eff);
        g_next = FULL - dk[2*CHAN_W-1:CHAN_W];
    end

    always_comb
    begin
        n6_next.red   = scale_ch(pix_q5_reg.color.red,   g_reg);
        n6_next.green = scale_ch(pix_q5_reg.color.green, g_reg);
        n6_next.blue  = scale_ch(pix_q5_reg.color.blue,  g_reg);
        a7_next.red   = ease_wt(pix_q6_reg.color.red,   n6_reg.red,   pix_q6_reg.coverage);
        a7_next.green = ease_wt(pix_q6_reg.color.green, n6_reg.green, pix_q6_reg.coverage);
        a7_next.blue  = ease_wt(pix_q6_reg.color.blue,  n6_reg.blue,  pix_q6_reg.coverage);
    end

    always_comb
    begin
        if (pix_q7_reg.masked)
        begin
            res_next.red   = ease_out(pix_q7_reg.color.red,   a7_reg.red);
            res_next.green = ease_out(pix_q7_reg.color.green, a7_reg.green);
            res_next.blue  = ease_out(pix_q7_reg.color.blue,  a7_reg.blue);
        end
        else
        begin
            res_next = n7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg                  <= x_pos;
            y0_reg                  <= y_pos;
            pix0_reg.color.red      <= red_in;
            pix0_reg.color.green    <= green_in;
            pix0_reg.color.blue     <= blue_in;
            pix0_reg.coverage       <= coverage;
            pix0_reg.masked         <= masked;

            dx1_reg  <= dx1_next;
            dy1_reg  <= dy1_next;
            y1_reg   <= y0_reg;
            pix1_reg <= pix0_reg;

            pp_reg <= pp_next;
            for (int k = 0; k < K; k++)
            begin
                it_reg[k] <= it_next[k];
            end

            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            hit_reg    <= (it_reg[K-1].remm == '0);
            pix_q1_reg <= it_reg[K-1].pix;

            tube_reg   <= tube_next;
            line_reg   <= line_next;
            pix_q2_reg <= pix_q1_reg;

            prod_reg   <= (2*CHAN_W)'(line_reg) * (2*CHAN_W)'(tube_reg);
            pix_q3_reg <= pix_q2_reg;

            f_reg      <= p2[2*CHAN_W-1:CHAN_W];
            pix_q4_reg <= pix_q3_reg;

            g_reg      <= g_next;
            pix_q5_reg <= pix_q4_reg;

            n6_reg     <= n6_next;
            pix_q6_reg <= pix_q5_reg;

            a7_reg     <= a7_next;
            n7_reg     <= n6_reg;
            pix_q7_reg <= pix_q6_reg;
        end
    end

    // output register with one skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (out_ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_data_reg <= res_next;
            end
            else
            begin
                out_data_reg <= res_next;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign red_out   = out_data_reg.red;
    assign green_out = out_data_reg.green;
    assign blue_out  = out_data_reg.blue;

    `CRTSV_ASSERT_NOW(a_skid_behind_out, skid_vld_reg, out_vld_reg, "skid word without output word")
    `CRTSV_ASSERT_NEXT(a_stall_fills_skid, out_vld_reg && !out_ready && push, skid_vld_reg, "stalled word not parked in skid")
    `CRTSV_ASSERT_NEXT(a_skid_drains, skid_vld_reg && out_ready, !skid_vld_reg && out_vld_reg, "skid word not moved to output")
    `CRTSV_ASSERT_NOW(a_no_invented_word, $rose(out_vld_reg), $past(push), "output word without a finished item")

endmodule

@@ tb/crt_pixel_checker.sv @@
module crt_pixel_checker
    import crtsv_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [COORD_BITS-1:0] x_pos,
    input  logic [COORD_BITS-1:0] y_pos,
    input  logic [CHAN_W-1:0]     red_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     blue_in,
    input  logic [CHAN_W-1:0]     coverage,
    input  logic                  masked,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [CHAN_W-1:0]     red_out,
    input  logic [CHAN_W-1:0]     green_out,
    input  logic [CHAN_W-1:0]     blue_out,

    output int                    mismatch_count,
    output int                    pending_words
);

    logic [SPACING_W-1:0] line_spacing_q;
    logic [DARK_W-1:0]    line_darkness_q;
    logic [STR_W-1:0]     strength_q;
    logic [SIZE_W-1:0]    image_width_q;
    logic [SIZE_W-1:0]    image_height_q;

    rgb_t expected_colors[$];
    rgb_t want;

    // normalized distance from the center along one axis, 0..255 inside the image
    function automatic longint center_offset(input longint pos, input longint size);
        longint d;
        d = (2 * pos >= size) ? 2 * pos - size : size - 2 * pos;
        return (size == 0) ? 0 : d * 255 / size;
    endfunction

    function automatic logic [CHAN_W-1:0] shade_channel(input int c, input int f,
                                                        input int cov, input logic m);
        int n;
        n = (c * f) >> 8;
        if (!m)
            return n[CHAN_W-1:0];
        if (cov == 0)
            return c[CHAN_W-1:0];
        // floor of a negative step: round the magnitude up
        return CHAN_W'(c - (((c - n) * cov + 255) >> 8));
    endfunction

    function automatic rgb_t darken_pixel(input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y,
                                          input rgb_t color,
                                          input logic [CHAN_W-1:0] cov,
                                          input logic m);
        longint nx;
        longint ny;
        longint corner;
        int spacing;
        int str;
        int row_gain;
        int tube;
        int f;
        rgb_t r;
        spacing = (line_spacing_q == 0) ? 1 : int'(line_spacing_q);
        str = (strength_q > 256) ? 256 : int'(strength_q);
        row_gain = (int'(y) % spacing == 0) ? 255 - int'(line_darkness_q) : 255;
        nx = center_offset(longint'(x), longint'(image_width_q));
        ny = center_offset(longint'(y), longint'(image_height_q));
        corner = (nx * nx + ny * ny) >> 8;
        if (corner <= 210)
            tube = 255;
        else if (corner >= 425)
            tube = 40;
        else
            tube = 465 - int'(corner);
        f = row_gain * tube / 255;
        f = 255 - (((255 - f) * str) >> 8);
        r.red   = shade_channel(int'(color.red), f, int'(cov), m);
        r.green = shade_channel(int'(color.green), f, int'(cov), m);
        r.blue  = shade_channel(int'(color.blue), f, int'(cov), m);
        return r;
    endfunction

    function automatic void compare_channel(input string name, input logic [CHAN_W-1:0] exp_v,
                                            input logic [CHAN_W-1:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_spacing_q  <= RST_LINE_SPACING;
            line_darkness_q <= RST_LINE_DARKNESS;
            strength_q      <= RST_STRENGTH;
            image_width_q   <= RST_IMAGE_WIDTH;
            image_height_q  <= RST_IMAGE_HEIGHT;
            expected_colors.delete();
            mismatch_count = 0;
            pending_words <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_colors.push_back(darken_pixel(x_pos, y_pos,
                                                       '{red_in, green_in, blue_in},
                                                       coverage, masked));
            if (out_valid && out_ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $display("%0t: unexpected output word, expected none, got %0d %0d %0d",
                             $time, red_out, green_out, blue_out);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    compare_channel("red_out", want.red, red_out);
                    compare_channel("green_out", want.green, green_out);
                    compare_channel("blue_out", want.blue, blue_out);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINE_SPACING:  line_spacing_q  <= cfg_data[SPACING_W-1:0];
                    CFG_LINE_DARKNESS: line_darkness_q <= cfg_data[DARK_W-1:0];
                    CFG_STRENGTH:      strength_q      <= cfg_data[STR_W-1:0];
                    CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data[SIZE_W-1:0];
                    CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            pending_words <= expected_colors.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    import crtsv_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int WAIT_MAX       = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    // leave room after the last word for stray words
    localparam int TAIL_CYCLES    = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_PIXELS   = 95;
    localparam int CFG_WRITES     = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [COORD_BITS-1:0] x_pos;
    logic [COORD_BITS-1:0] y_pos;
    logic [CHAN_W-1:0]     red_in;
    logic [CHAN_W-1:0]     green_in;
    logic [CHAN_W-1:0]     blue_in;
    logic [CHAN_W-1:0]     coverage;
    logic                  masked;
    logic                  out_valid;
    logic                  out_ready;
    logic [CHAN_W-1:0]     red_out;
    logic [CHAN_W-1:0]     green_out;
    logic [CHAN_W-1:0]     blue_out;

    int mismatch_count;
    int pending_words;
    int quiet_cycles;
    logic steady;
    logic [SPACING_W-1:0] cur_spacing;
    logic [SIZE_W-1:0]    cur_width;
    logic [SIZE_W-1:0]    cur_height;

    crt_scanline_vignette_pixel_top #(.COORD_BITS(COORD_BITS)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_pos(x_pos), .y_pos(y_pos),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .coverage(coverage), .masked(masked),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out)
    );

    crt_pixel_checker #(.COORD_BITS(COORD_BITS)) pixel_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .x_pos(x_pos), .y_pos(y_pos),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .coverage(coverage), .masked(masked),
        .out_valid(out_valid), .out_ready(out_ready),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .mismatch_count(mismatch_count), .pending_words(pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    function automatic logic [CHAN_W-1:0] draw_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] cov,
                              input logic m);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        x_pos    <= x;
        y_pos    <= y;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        coverage <= cov;
        masked   <= m;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        int top_x;
        int top_y;
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
        top_x = (cur_width > 4096) ? 4095 : int'(cur_width) - 1;
        top_y = (cur_height > 4096) ? 4095 : int'(cur_height) - 1;
        // mostly inside the image so the falloff curve gets exercised
        if (cur_width != 0 && $urandom_range(0, 3) != 0)
            x = COORD_BITS'($urandom_range(0, top_x));
        if (cur_height != 0 && $urandom_range(0, 3) != 0)
            y = COORD_BITS'($urandom_range(0, top_y));
        if (cur_spacing > 1 && $urandom_range(0, 3) == 0)
            y = COORD_BITS'(int'(cur_spacing) * $urandom_range(0, 4095 / int'(cur_spacing)));
        send_pixel(x, y, draw_level(), draw_level(), draw_level(), draw_level(),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic wait_all_words();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] spacing,
                                input logic [CFG_DATA_W-1:0] dark,
                                input logic [CFG_DATA_W-1:0] str,
                                input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h);
        logic [CFG_IDX_W-1:0]  reg_order [CFG_WRITES];
        logic [CFG_DATA_W-1:0] reg_value [CFG_WRITES];
        reg_order = '{CFG_LINE_SPACING, CFG_LINE_DARKNESS, CFG_STRENGTH,
                      CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_UNUSED};
        reg_value = '{spacing, dark, str, w, h, CFG_DATA_W'($urandom)};
        wait_all_words();
        for (int i = 0; i < CFG_WRITES; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= reg_value[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_spacing = spacing[SPACING_W-1:0];
        cur_width   = w;
        cur_height  = h;
    endtask

    // result side: per word stall, none while steady
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] spacing;
        logic [CFG_DATA_W-1:0] dark;
        logic [CFG_DATA_W-1:0] str;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LINE_SPACING;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        x_pos     <= '0;
        y_pos     <= '0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        coverage  <= '0;
        masked    <= 1'b0;
        steady      = 1'b0;
        cur_spacing = RST_LINE_SPACING;
        cur_width   = RST_IMAGE_WIDTH;
        cur_height  = RST_IMAGE_HEIGHT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: center, edges, corner, outside, blend corners
        send_pixel(160, 120, 255, 255, 255, 0, 0);
        send_pixel(160, 121, 255, 255, 255, 255, 0);
        send_pixel(0, 0, 255, 128, 1, 0, 0);
        send_pixel(4095, 4095, 255, 255, 255, 0, 0);
        send_pixel(319, 239, 0, 0, 0, 255, 1);
        send_pixel(200, 100, 200, 100, 50, 0, 1);
        send_pixel(200, 100, 200, 100, 50, 255, 1);
        send_pixel(200, 100, 200, 100, 50, 1, 1);
        send_pixel(250, 30, 255, 255, 255, 128, 1);
        send_pixel(0, 4095, 170, 85, 255, 0, 0);
        send_pixel(4095, 0, 85, 170, 0, 255, 1);

        // zero spacing, full darkness, strength over full scale, zero size
        program_regs(0, 255, 511, 0, 0);
        send_pixel(1234, 777, 255, 255, 255, 0, 0);
        send_pixel(4095, 4095, 200, 10, 99, 77, 1);
        send_pixel(0, 1, 255, 0, 255, 0, 0);

        program_regs(4095, 0, 0, 8191, 1);
        send_pixel(0, 0, 255, 255, 255, 0, 0);
        send_pixel(4095, 4095, 255, 255, 255, 0, 0);
        send_pixel(2048, 4095, 90, 180, 255, 200, 1);

        program_regs(1, 255, 257, 4096, 4096);
        send_pixel(2048, 2048, 255, 255, 255, 0, 0);
        send_pixel(0, 0, 255, 255, 255, 200, 1);
        send_pixel(4095, 2048, 33, 66, 255, 255, 1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            spacing = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 4095))
                                                 : CFG_DATA_W'($urandom_range(0, 8));
            dark = CFG_DATA_W'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: str = CFG_DATA_W'(256);
                1: str = CFG_DATA_W'($urandom_range(0, 511));
                default: str = CFG_DATA_W'($urandom_range(0, 256));
            endcase
            w = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(1, 4096));
            h = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(1, 4096));
            // junk above the register width must be dropped
            if (p % 2 == 1)
            begin
                spacing = spacing | (CFG_DATA_W'($urandom) << SPACING_W);
                dark    = dark | (CFG_DATA_W'($urandom) << DARK_W);
                str     = str | (CFG_DATA_W'($urandom) << STR_W);
            end
            steady = 1'b0;
            program_regs(spacing, dark, str, w, h);
            steady = (p % 3 == 2);
            for (int i = 0; i < PHASE_PIXELS; i++)
                send_random_pixel();
        end

        wait_all_words();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_words == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
